/* hdl/tmrc_pkg.sv */
// Shared types and constants of the tile map rectangle collision block.
package tmrc_pkg;

    localparam int TILE_SHIFT  = 5;
    localparam int TILE_SIDE   = 1 << TILE_SHIFT;
    localparam int MAP_ROWS    = 16;
    localparam int MAP_COLS    = 256;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 8;
    localparam int MAP_CELLS   = MAP_ROWS * MAP_COLS;
    localparam int VAL_W       = 11;
    localparam int LIM_W       = 10;
    localparam int ROWS_W      = 5;
    localparam int COLS_W      = 9;
    localparam int POS_W       = 16;
    localparam int SIZE_W      = 12;
    localparam int END_W       = 17;
    localparam int GEO_W       = 18;
    localparam int OVL_W       = 9;
    localparam int REM_SPLIT   = 5;
    localparam int FIFO_DEPTH  = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    typedef enum logic [1:0] {
        REG_OBSTACLE_LIMIT = 2'd0,
        REG_ATLAS_COLUMNS  = 2'd1,
        REG_ROWS_IN_USE    = 2'd2,
        REG_COLS_IN_USE    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Configuration as seen by the datapath: divisor never zero, sizes clamped to the map.
    typedef struct packed {
        logic [LIM_W-1:0]  obstacle_limit;
        logic [LIM_W-1:0]  divisor;
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic                    is_write;
        logic                    scan;
        logic [ROW_W-1:0]        tile_row;
        logic [COL_W-1:0]        tile_col;
        logic signed [VAL_W-1:0] tile_value;
        logic [ROW_W-1:0]        row0;
        logic [ROW_W-1:0]        row1;
        logic [COL_W-1:0]        col0;
        logic [COL_W-1:0]        col1;
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
        logic signed [END_W-1:0] rx_end;
        logic signed [END_W-1:0] ry_end;
    } t_cmd;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] inter_x;
        logic signed [POS_W-1:0] inter_y;
        logic [OVL_W-1:0]        inter_w;
        logic [OVL_W-1:0]        inter_h;
    } t_res;

    // One restoring step of the remainder: shift in a bit, subtract when it fits.
    function automatic logic [VAL_W-1:0] rem_step(input logic [VAL_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [LIM_W-1:0] divisor);
        logic [VAL_W-1:0] t;
        t = {rem[VAL_W-2:0], bit_in};
        return (t >= {1'b0, divisor}) ? (t - {1'b0, divisor}) : t;
    endfunction

endpackage

/* hdl/tmrc_front.sv */
// Front end: accepts words, decodes them and works out the clamped cell range of a query.
module tmrc_front (
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [tmrc_pkg::IN_TDATA_W-1:0]    i_data,
    input  logic                               i_func,
    input  tmrc_pkg::t_cfg                     i_cfg,
    output logic                               o_push,
    output tmrc_pkg::t_cmd                     o_cmd,
    input  logic                               i_full
);
    import tmrc_pkg::*;

    logic signed [POS_W-1:0]  rx, ry;
    logic [SIZE_W-1:0]        rw, rh;
    logic signed [END_W-1:0]  rx_end, ry_end;
    logic signed [GEO_W-1:0]  last_x, last_y;
    logic signed [13:0]       c0, c1, r0, r1, col_max, row_max;
    logic                     scan_x, scan_y;

    assign rx = i_data[38:23];
    assign ry = i_data[54:39];
    assign rw = i_data[66:55];
    assign rh = i_data[78:67];

    always_comb begin
        rx_end  = {rx[POS_W-1], rx} + $signed({5'b0, rw});
        ry_end  = {ry[POS_W-1], ry} + $signed({5'b0, rh});
        last_x  = {rx_end[END_W-1], rx_end} - 18'sd1;
        last_y  = {ry_end[END_W-1], ry_end} - 18'sd1;
        // Floor division is enough here: cells it adds have no positive overlap.
        c0      = rx[POS_W-1] ? 14'sd0 : $signed({3'b0, rx[POS_W-1:TILE_SHIFT]});
        r0      = ry[POS_W-1] ? 14'sd0 : $signed({3'b0, ry[POS_W-1:TILE_SHIFT]});
        c1      = {last_x[GEO_W-1], last_x[GEO_W-1:TILE_SHIFT]};
        r1      = {last_y[GEO_W-1], last_y[GEO_W-1:TILE_SHIFT]};
        col_max = $signed({5'b0, i_cfg.cols}) - 14'sd1;
        row_max = $signed({9'b0, i_cfg.rows}) - 14'sd1;
        if (c1 > col_max) begin
            c1 = col_max;
        end
        if (r1 > row_max) begin
            r1 = row_max;
        end
        scan_x = (rw != '0) && (i_cfg.cols != '0) && (c0 <= c1);
        scan_y = (rh != '0) && (i_cfg.rows != '0) && (r0 <= r1);
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.is_write   = (i_func == FUNC_WRITE);
        o_cmd.scan       = scan_x && scan_y;
        o_cmd.tile_row   = i_data[3:0];
        o_cmd.tile_col   = i_data[11:4];
        o_cmd.tile_value = i_data[22:12];
        o_cmd.row0       = r0[ROW_W-1:0];
        o_cmd.row1       = r1[ROW_W-1:0];
        o_cmd.col0       = c0[COL_W-1:0];
        o_cmd.col1       = c1[COL_W-1:0];
        o_cmd.rx         = rx;
        o_cmd.ry         = ry;
        o_cmd.rx_end     = rx_end;
        o_cmd.ry_end     = ry_end;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

/* hdl/tmrc_fifo.sv */
// Short command queue between the front end and the back end.
module tmrc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmrc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tmrc_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_full
);
    import tmrc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_cmd               r_entry [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]     r_count;

    assign o_cmd   = r_entry[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PTR_W+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_entry[r_wr_ptr] <= i_cmd;
                r_wr_ptr          <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/tmrc_back.sv */
// Back end: tile memory, cell scanner, obstacle test pipeline and result register.
module tmrc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tmrc_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  tmrc_pkg::t_cfg i_cfg,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output tmrc_pkg::t_res o_res
);
    import tmrc_pkg::*;

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic                    r_issue;
    logic                    r_found;
    t_res                    r_hit;
    logic                    r_out_valid;
    t_res                    r_out;

    logic signed [VAL_W-1:0] r_mem [MAP_CELLS];
    logic signed [VAL_W-1:0] r_rd_data;

    logic                    r_s1_valid;
    logic [ROW_W-1:0]        r_s1_row;
    logic [COL_W-1:0]        r_s1_col;

    logic                    r_s2_valid;
    logic [VAL_W-1:0]        r_s2_rem;
    logic [REM_SPLIT-1:0]    r_s2_low;
    logic                    r_s2_neg;
    logic                    r_s2_empty;
    logic                    r_s2_ovl;
    logic signed [POS_W-1:0] r_s2_lx, r_s2_ly;
    logic [OVL_W-1:0]        r_s2_w, r_s2_h;

    logic                    out_free, take_cmd, mem_we, scan_done, finish, issue;
    logic                    s1_neg, s1_empty, s2_obst, hit_now;
    logic [VAL_W-1:0]        s1_mag, s1_rem, s2_rem;
    logic signed [GEO_W-1:0] tx, ty, tx_end, ty_end, rx18, ry18, rxe18, rye18;
    logic signed [GEO_W-1:0] lx, ly, hx, hy, w, h;

    assign out_free  = !r_out_valid || i_res_ready;
    assign take_cmd  = (r_state == ST_IDLE) && i_cmd_valid
                       && (out_free || (!i_cmd.is_write && i_cmd.scan));
    assign mem_we    = take_cmd && i_cmd.is_write;
    assign scan_done = (r_state == ST_SCAN)
                       && (r_found || (!r_issue && !r_s1_valid && !r_s2_valid));
    assign finish    = scan_done && out_free;
    assign issue     = (r_state == ST_SCAN) && r_issue && !r_found;
    assign o_cmd_pop = take_cmd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{i_cmd.tile_row, i_cmd.tile_col}] <= i_cmd.tile_value;
        end
        r_rd_data <= r_mem[{r_row, r_col}];
    end

    // First half of the remainder and the overlap of the cell square with the rectangle.
    always_comb begin
        s1_neg   = r_rd_data[VAL_W-1];
        s1_empty = (r_rd_data == -11'sd1);
        s1_mag   = s1_neg ? (~r_rd_data + 11'd1) : r_rd_data;
        s1_rem   = '0;
        for (int i = VAL_W - 1; i >= REM_SPLIT; i--) begin
            s1_rem = rem_step(s1_rem, s1_mag[i], i_cfg.divisor);
        end
        tx     = $signed({5'b0, r_s1_col, 5'b0});
        ty     = $signed({9'b0, r_s1_row, 5'b0});
        tx_end = tx + GEO_W'(TILE_SIDE);
        ty_end = ty + GEO_W'(TILE_SIDE);
        rx18   = {{2{r_cmd.rx[POS_W-1]}}, r_cmd.rx};
        ry18   = {{2{r_cmd.ry[POS_W-1]}}, r_cmd.ry};
        rxe18  = {r_cmd.rx_end[END_W-1], r_cmd.rx_end};
        rye18  = {r_cmd.ry_end[END_W-1], r_cmd.ry_end};
        lx     = (rx18 > tx) ? rx18 : tx;
        ly     = (ry18 > ty) ? ry18 : ty;
        hx     = (rxe18 < tx_end) ? rxe18 : tx_end;
        hy     = (rye18 < ty_end) ? rye18 : ty_end;
        w      = hx - lx;
        h      = hy - ly;
    end

    // Second half of the remainder and the obstacle decision.
    always_comb begin
        s2_rem = r_s2_rem;
        for (int i = REM_SPLIT - 1; i >= 0; i--) begin
            s2_rem = rem_step(s2_rem, r_s2_low[i], i_cfg.divisor);
        end
        s2_obst = !r_s2_empty && ((r_s2_neg && (s2_rem != '0))
                                  || (s2_rem < {1'b0, i_cfg.obstacle_limit}));
        hit_now = r_s2_valid && !r_found && s2_obst && r_s2_ovl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_found     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (take_cmd) begin
                if (i_cmd.is_write || !i_cmd.scan) begin
                    r_out_valid <= 1'b1;
                    r_out       <= '0;
                end else begin
                    r_state <= ST_SCAN;
                    r_cmd   <= i_cmd;
                    r_row   <= i_cmd.row0;
                    r_col   <= i_cmd.col0;
                    r_issue <= 1'b1;
                    r_found <= 1'b0;
                end
            end
            if (issue) begin
                if (r_col == r_cmd.col1) begin
                    r_col <= r_cmd.col0;
                    if (r_row == r_cmd.row1) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            r_s1_valid <= issue;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s2_valid <= r_s1_valid;
            r_s2_rem   <= s1_rem;
            r_s2_low   <= s1_mag[REM_SPLIT-1:0];
            r_s2_neg   <= s1_neg;
            r_s2_empty <= s1_empty;
            r_s2_ovl   <= (w > 18'sd0) && (h > 18'sd0);
            r_s2_lx    <= lx[POS_W-1:0];
            r_s2_ly    <= ly[POS_W-1:0];
            r_s2_w     <= w[OVL_W-1:0];
            r_s2_h     <= h[OVL_W-1:0];
            if (hit_now) begin
                r_found       <= 1'b1;
                r_hit.hit     <= 1'b1;
                r_hit.inter_x <= r_s2_lx;
                r_hit.inter_y <= r_s2_ly;
                r_hit.inter_w <= r_s2_w;
                r_hit.inter_h <= r_s2_h;
            end
            if (finish) begin
                r_state     <= ST_IDLE;
                r_issue     <= 1'b0;
                r_s1_valid  <= 1'b0;
                r_s2_valid  <= 1'b0;
                r_out_valid <= 1'b1;
                r_out       <= r_found ? r_hit : '0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* hdl/tile_map_rect_collision.sv */
// Top level of the tile map rectangle collision block with its register port.
// A tile write is stored by the back end. A query reads one scanned cell per cycle
// through the single tile memory read port, then passes through the pipeline and result
// handoff, and the scan stops at the first hit. The front end classifies each word and
// keeps accepting while the two-entry command queue has room. The tile memory is not
// cleared after reset.
module tile_map_rect_collision (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tile_row[3:0], tile_col[11:4], tile_value[22:12], rect_x[38:23], rect_y[54:39],
    // rect_w[66:55], rect_h[78:67]
    input  logic [tmrc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit[0], inter_x[16:1], inter_y[32:17], inter_w[41:33], inter_h[50:42]
    output logic [tmrc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmrc_pkg::PADDR_W-1:0]        paddr,
    input  logic [tmrc_pkg::PDATA_W-1:0]        pwdata,
    output logic [tmrc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import tmrc_pkg::*;

    logic [LIM_W-1:0]  r_obstacle_limit;
    logic [LIM_W-1:0]  r_atlas_columns;
    logic [ROWS_W-1:0] r_rows_in_use;
    logic [COLS_W-1:0] r_cols_in_use;
    t_cfg              cfg;
    t_reg_idx          reg_idx;
    logic              cfg_we;
    logic              push, full, cmd_valid, cmd_pop;
    t_cmd              front_cmd, queue_cmd;
    t_res              res;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle_limit <= LIM_W'(0);
            r_atlas_columns  <= LIM_W'(9);
            r_rows_in_use    <= ROWS_W'(MAP_ROWS);
            r_cols_in_use    <= COLS_W'(MAP_COLS);
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_OBSTACLE_LIMIT: r_obstacle_limit <= pwdata[LIM_W-1:0];
                REG_ATLAS_COLUMNS:  r_atlas_columns  <= pwdata[LIM_W-1:0];
                REG_ROWS_IN_USE:    r_rows_in_use    <= pwdata[ROWS_W-1:0];
                REG_COLS_IN_USE:    r_cols_in_use    <= pwdata[COLS_W-1:0];
                default:            r_obstacle_limit <= r_obstacle_limit;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OBSTACLE_LIMIT: prdata = PDATA_W'(r_obstacle_limit);
            REG_ATLAS_COLUMNS:  prdata = PDATA_W'(r_atlas_columns);
            REG_ROWS_IN_USE:    prdata = PDATA_W'(r_rows_in_use);
            REG_COLS_IN_USE:    prdata = PDATA_W'(r_cols_in_use);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        cfg.obstacle_limit = r_obstacle_limit;
        cfg.divisor        = (r_atlas_columns == '0) ? LIM_W'(1) : r_atlas_columns;
        cfg.rows = (r_rows_in_use > ROWS_W'(MAP_ROWS)) ? ROWS_W'(MAP_ROWS) : r_rows_in_use;
        cfg.cols = (r_cols_in_use > COLS_W'(MAP_COLS)) ? COLS_W'(MAP_COLS) : r_cols_in_use;
    end

    tmrc_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_func  (s_axis_tuser),
        .i_cfg   (cfg),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    tmrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (queue_cmd),
        .o_valid (cmd_valid),
        .o_full  (full)
    );

    tmrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {5'b0, res.inter_h, res.inter_w, res.inter_y, res.inter_x, res.hit};

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[50:1] == '0)
        else $error("result without hit carries nonzero fields");

    a_hit_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0]
        |-> m_axis_tdata[41:33] != '0 && m_axis_tdata[41:33] <= OVL_W'(TILE_SIDE))
        else $error("hit width outside one tile");

    a_hit_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0]
        |-> m_axis_tdata[50:42] != '0 && m_axis_tdata[50:42] <= OVL_W'(TILE_SIDE))
        else $error("hit height outside one tile");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> cfg.divisor != '0)
        else $error("obstacle test divisor is zero");

endmodule

/* test/tb.sv */
// Self-checking testbench for the tile map rectangle collision block.
`timescale 1ns / 1ps

module tb;
    import tmrc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_WORDS = 135;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 7;

    typedef struct packed {
        t_func                   func;
        logic [ROW_W-1:0]        tile_row;
        logic [COL_W-1:0]        tile_col;
        logic signed [VAL_W-1:0] tile_value;
        logic signed [POS_W-1:0] rect_x;
        logic signed [POS_W-1:0] rect_y;
        logic [SIZE_W-1:0]       rect_w;
        logic [SIZE_W-1:0]       rect_h;
    } t_word;

    typedef struct packed {
        t_word word;
        logic  typed;
        t_res  want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tile_row[3:0], tile_col[11:4], tile_value[22:12], rect_x[38:23], rect_y[54:39],
    // rect_w[66:55], rect_h[78:67]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // func[0]
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // hit[0], inter_x[16:1], inter_y[32:17], inter_w[41:33], inter_h[50:42]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    logic signed [VAL_W-1:0] tile_map [MAP_ROWS][MAP_COLS];
    int cfg_limit = 0;
    int cfg_atlas = 9;
    int cfg_rows  = 16;
    int cfg_cols  = 256;

    t_res collision_q [$];
    int   mismatches = 0;
    bit   no_idle = 1'b1;
    bit   hold_armed = 1'b0;

    t_row directed_rows [19];
    int   phase_cfg [PHASES][4] = '{
        '{0, 9, 16, 256},
        '{1023, 1023, 31, 511},
        '{5, 0, 16, 256},
        '{3, 1, 1, 1},
        '{12, 16, 0, 0},
        '{0, 9, 16, 256},
        '{0, 9, 16, 256}
    };

    tile_map_rect_collision i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res predict_collision(input t_word w);
        t_res r;
        int rx, ry, rw, rh, nrows, ncols, divisor;
        int row0, row1, col0, col1, idx, tx, ty, lx, ly, hx, hy;
        r = '0;
        if (w.func == FUNC_WRITE) begin
            tile_map[w.tile_row][w.tile_col] = w.tile_value;
            return r;
        end
        rx = $signed(w.rect_x);
        ry = $signed(w.rect_y);
        rw = w.rect_w;
        rh = w.rect_h;
        if (rw == 0 || rh == 0) begin
            return r;
        end
        nrows = (cfg_rows > MAP_ROWS) ? MAP_ROWS : cfg_rows;
        ncols = (cfg_cols > MAP_COLS) ? MAP_COLS : cfg_cols;
        divisor = (cfg_atlas == 0) ? 1 : cfg_atlas;
        row0 = ry / TILE_SIDE;
        col0 = rx / TILE_SIDE;
        row1 = (ry + rh - 1) / TILE_SIDE;
        col1 = (rx + rw - 1) / TILE_SIDE;
        if (row0 < 0) row0 = 0;
        if (col0 < 0) col0 = 0;
        if (row1 > nrows - 1) row1 = nrows - 1;
        if (col1 > ncols - 1) col1 = ncols - 1;
        for (int row = row0; row <= row1; row++) begin
            for (int col = col0; col <= col1; col++) begin
                idx = tile_map[row][col];
                if (idx == -1 || (idx % divisor) >= cfg_limit) continue;
                tx = col * TILE_SIDE;
                ty = row * TILE_SIDE;
                lx = (rx > tx) ? rx : tx;
                ly = (ry > ty) ? ry : ty;
                hx = (rx + rw < tx + TILE_SIDE) ? rx + rw : tx + TILE_SIDE;
                hy = (ry + rh < ty + TILE_SIDE) ? ry + rh : ty + TILE_SIDE;
                if (hx - lx <= 0 || hy - ly <= 0) continue;
                r.hit = 1'b1;
                r.inter_x = POS_W'(lx);
                r.inter_y = POS_W'(ly);
                r.inter_w = OVL_W'(hx - lx);
                r.inter_h = OVL_W'(hy - ly);
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_word random_word();
        t_word w;
        int px, py;
        w.func = ($urandom_range(0, 9) < 3) ? FUNC_WRITE : FUNC_QUERY;
        w.tile_row = ROW_W'($urandom);
        w.tile_col = COL_W'($urandom);
        case ($urandom_range(0, 3))
            0, 1: w.tile_value = '1;
            2: w.tile_value = VAL_W'($urandom_range(0, 63));
            default: w.tile_value = VAL_W'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0: begin
                w.rect_x = POS_W'($urandom);
                w.rect_y = POS_W'($urandom);
                w.rect_w = SIZE_W'($urandom);
                w.rect_h = SIZE_W'($urandom);
            end
            1: begin
                w.rect_x = POS_W'($urandom_range(0, 8191));
                w.rect_y = POS_W'($urandom_range(0, 511));
                w.rect_w = SIZE_W'($urandom);
                w.rect_h = SIZE_W'($urandom_range(0, 64));
            end
            default: begin
                px = int'($urandom_range(0, 8300)) - 64;
                py = int'($urandom_range(0, 560)) - 40;
                w.rect_x = POS_W'(px);
                w.rect_y = POS_W'(py);
                w.rect_w = SIZE_W'($urandom_range(0, 96));
                w.rect_h = SIZE_W'($urandom_range(0, 96));
            end
        endcase
        return w;
    endfunction

    function automatic t_row tile_write_row(input int r, input int c, input int v);
        t_row e;
        e = '0;
        e.word.func = FUNC_WRITE;
        e.word.tile_row = ROW_W'(r);
        e.word.tile_col = COL_W'(c);
        e.word.tile_value = VAL_W'(v);
        e.typed = 1'b1;
        return e;
    endfunction

    function automatic t_row query_row(input int x, input int y, input int w, input int h,
                                       input bit typed, input t_res want);
        t_row e;
        e = '0;
        e.word.func = FUNC_QUERY;
        e.word.rect_x = POS_W'(x);
        e.word.rect_y = POS_W'(y);
        e.word.rect_w = SIZE_W'(w);
        e.word.rect_h = SIZE_W'(h);
        e.typed = typed;
        e.want = want;
        return e;
    endfunction

    task automatic send_word(input t_word w, input bit typed, input t_res want);
        int gap;
        t_res predicted;
        logic [IN_TDATA_W-1:0] d;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        d = '0;
        d[3:0]   = w.tile_row;
        d[11:4]  = w.tile_col;
        d[22:12] = w.tile_value;
        d[38:23] = w.rect_x;
        d[54:39] = w.rect_y;
        d[66:55] = w.rect_w;
        d[78:67] = w.rect_h;
        s_axis_tdata  <= d;
        s_axis_tuser  <= w.func;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_collision(w);
        collision_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (collision_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OBSTACLE_LIMIT: cfg_limit = value[LIM_W-1:0];
            REG_ATLAS_COLUMNS:  cfg_atlas = value[LIM_W-1:0];
            REG_ROWS_IN_USE:    cfg_rows  = value[ROWS_W-1:0];
            REG_COLS_IN_USE:    cfg_cols  = value[COLS_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit     = m_axis_tdata[0];
            got.inter_x = m_axis_tdata[16:1];
            got.inter_y = m_axis_tdata[32:17];
            got.inter_w = m_axis_tdata[41:33];
            got.inter_h = m_axis_tdata[50:42];
            if (collision_q.size() == 0) begin
                $display("%0t: result word with nothing expected, got %h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = collision_q.pop_front();
                compare_field("hit", want.hit, got.hit);
                compare_field("inter_x", want.inter_x, got.inter_x);
                compare_field("inter_y", want.inter_y, got.inter_y);
                compare_field("inter_w", want.inter_w, got.inter_w);
                compare_field("inter_h", want.inter_h, got.inter_h);
            end
        end
    end

    // The result side may pause after a word; once per run it holds off for a long stretch.
    initial begin
        int pause;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                pause = no_idle ? 0 : $urandom_range(0, 16);
                if (hold_armed) begin
                    hold_armed = 1'b0;
                    pause = HOLD_CYCLES;
                end
                if (pause > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        t_word w;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The map memory powers up undefined, so every cell is loaded before any query.
        for (int r = 0; r < MAP_ROWS; r++) begin
            for (int c = 0; c < MAP_COLS; c++) begin
                w = random_word();
                w.func = FUNC_WRITE;
                w.tile_row = ROW_W'(r);
                w.tile_col = COL_W'(c);
                send_word(w, 1'b0, '0);
            end
        end
        drain();

        write_reg(REG_OBSTACLE_LIMIT, 4);
        write_reg(REG_ATLAS_COLUMNS, 9);
        write_reg(REG_ROWS_IN_USE, 16);
        write_reg(REG_COLS_IN_USE, 256);
        no_idle = 1'b0;

        directed_rows = '{
            tile_write_row(0, 0, 0),
            tile_write_row(15, 255, 1023),
            tile_write_row(0, 1, -1024),
            tile_write_row(1, 0, -1),
            tile_write_row(1, 1, -5),
            tile_write_row(15, 254, 1022),
            query_row(0, 0, 32, 32, 1'b1, t_res'{1'b1, 16'sd0, 16'sd0, 9'd32, 9'd32}),
            query_row(0, 0, 0, 32, 1'b1, '0),
            query_row(0, 0, 32, 0, 1'b1, '0),
            query_row(-32768, -32768, 4095, 4095, 1'b1, '0),
            query_row(32767, 32767, 4095, 4095, 1'b1, '0),
            query_row(-20, -20, 40, 40, 1'b0, '0),
            query_row(-31, 0, 31, 32, 1'b0, '0),
            query_row(16, 0, 32, 32, 1'b0, '0),
            query_row(32, 0, 32, 32, 1'b0, '0),
            query_row(32, 32, 32, 32, 1'b0, '0),
            query_row(8160, 480, 32, 32, 1'b0, '0),
            query_row(8100, 470, 4095, 4095, 1'b0, '0),
            query_row(0, 0, 4095, 4095, 1'b0, '0)
        };
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p >= 5) begin
                phase_cfg[p][0] = $urandom_range(0, 1023);
                phase_cfg[p][1] = $urandom_range(0, 1023);
                phase_cfg[p][2] = $urandom_range(0, 31);
                phase_cfg[p][3] = $urandom_range(0, 511);
            end
            drain();
            for (int k = 0; k < 4; k++) begin
                write_reg(t_reg_idx'(k), phase_cfg[p][k]);
            end
            no_idle = (p == 2 || p == 4);
            hold_armed = (p == 1);
            repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && collision_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tmrc_pkg.sv
hdl/tmrc_front.sv
hdl/tmrc_fifo.sv
hdl/tmrc_back.sv
hdl/tile_map_rect_collision.sv
test/tb.sv
